// File: rtl/core/tbbc_pkg.sv
// ----------------------------------------------------------------------------
// tbbc_pkg - shared types and constants
// Byte and group types, result kind codes and register map of the
// threshold bitmap byte compactor.
// ----------------------------------------------------------------------------
package tbbc_pkg;

  localparam int GroupBytes  = 8;
  localparam int ByteW       = 8;
  localparam int KeptOffsetW = 24;
  localparam int CountW      = 4;   // holds 0..GroupBytes
  localparam int PosW        = 3;   // indexes 0..GroupBytes-1
  localparam int PaddrW      = 3;
  localparam int PdataW      = 32;

  typedef logic [ByteW-1:0]       byte_t;
  typedef byte_t                  group_t [GroupBytes];
  typedef logic [GroupBytes-1:0]  bitmap_t;
  typedef logic [CountW-1:0]      count_t;

  localparam byte_t ThresholdReset = 8'd25;

  // result kind codes
  localparam logic KIND_BITMAP = 1'b0;
  localparam logic KIND_BYTE   = 1'b1;

  // register word indexes
  localparam logic REG_KEEP_THRESHOLD = 1'b0;

endpackage

// File: rtl/core/tbbc_if.sv
// ----------------------------------------------------------------------------
// tbbc channel interfaces
// Valid/ready channels for pixel groups in and compacted results out.
// ----------------------------------------------------------------------------
interface tbbc_in_if
  import tbbc_pkg::*;
;
  logic  valid;
  logic  ready;
  byte_t byte_0;
  byte_t byte_1;
  byte_t byte_2;
  byte_t byte_3;
  byte_t byte_4;
  byte_t byte_5;
  byte_t byte_6;
  byte_t byte_7;
  logic  frame_start;

  modport source (
    output valid, byte_0, byte_1, byte_2, byte_3, byte_4, byte_5, byte_6, byte_7,
           frame_start,
    input  ready
  );
  modport sink (
    input  valid, byte_0, byte_1, byte_2, byte_3, byte_4, byte_5, byte_6, byte_7,
           frame_start,
    output ready
  );
endinterface

interface tbbc_out_if
  import tbbc_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic                   kind;
  byte_t                  payload;
  logic [KeptOffsetW-1:0] kept_offset;
  logic                   group_last;

  modport source (
    output valid, kind, payload, kept_offset, group_last,
    input  ready
  );
  modport sink (
    input  valid, kind, payload, kept_offset, group_last,
    output ready
  );
endinterface

// File: rtl/core/threshold_bitmap_byte_compactor.sv
// ----------------------------------------------------------------------------
// threshold_bitmap_byte_compactor - bitmap zero-suppression encoder
// Per group of eight bytes: one bitmap result, then the kept bytes in order.
// ----------------------------------------------------------------------------
// The bitmap result of an item is driven from the serializer registers, which load it from the input register.
// Each item yields 1 + (kept bytes) results, 1 to 9, through the single
//   output channel carrying one result per cycle while dout.ready is high; an input
//   register holds the next item while the current one drains.
// Reset: rst (synchronous) empties both stages, clears the running count and
//   sets keep_threshold to 25.
module threshold_bitmap_byte_compactor
  import tbbc_pkg::*;
#(
  parameter int OFFSET_BITS = 24
) (
  input  logic              clk,
  input  logic              rst,
  tbbc_in_if.sink           din,
  tbbc_out_if.source        dout,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  localparam int ExtW = (OFFSET_BITS > KeptOffsetW) ? OFFSET_BITS : KeptOffsetW;

  // configuration
  byte_t keep_threshold;
  logic  cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_threshold <= ThresholdReset;
    end else if (cfg_wr && (paddr[2] == REG_KEEP_THRESHOLD)) begin
      keep_threshold <= pwdata[ByteW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_KEEP_THRESHOLD) begin
      prdata = PdataW'(keep_threshold);
    end
  end

  // input register
  logic   s1_valid;
  group_t s1_bytes;
  logic   s1_frame_start;

  // serializer
  logic                   ser_valid;
  count_t                 ser_idx;
  count_t                 ser_nkept;
  bitmap_t                ser_bitmap;
  group_t                 ser_bytes;
  logic [OFFSET_BITS-1:0] ser_base;
  logic [OFFSET_BITS-1:0] kept_count;

  logic in_fire;
  logic out_fire;
  logic ser_last;
  logic ser_done;
  logic load;

  assign ser_last = (ser_idx == ser_nkept);
  assign out_fire = dout.valid && dout.ready;
  assign ser_done = out_fire && ser_last;
  assign load     = s1_valid && (!ser_valid || ser_done);
  assign din.ready = !s1_valid || load;
  assign in_fire  = din.valid && din.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_bytes[0]    <= din.byte_0;
      s1_bytes[1]    <= din.byte_1;
      s1_bytes[2]    <= din.byte_2;
      s1_bytes[3]    <= din.byte_3;
      s1_bytes[4]    <= din.byte_4;
      s1_bytes[5]    <= din.byte_5;
      s1_bytes[6]    <= din.byte_6;
      s1_bytes[7]    <= din.byte_7;
      s1_frame_start <= din.frame_start;
    end
  end

  // threshold compare and compaction of the waiting group
  bitmap_t                keep;
  count_t                 prefix [GroupBytes];
  count_t                 nkept;
  group_t                 packed_bytes;
  logic [OFFSET_BITS-1:0] base;
  logic [OFFSET_BITS-1:0] kept_count_next;

  always_comb begin
    count_t run;
    run = '0;
    for (int k = 0; k < GroupBytes; k++) begin
      keep[k]   = (s1_bytes[k] >= keep_threshold);
      prefix[k] = run;
      run       = run + count_t'(keep[k]);
    end
    nkept = run;
    for (int j = 0; j < GroupBytes; j++) begin
      packed_bytes[j] = '0;
      for (int k = 0; k < GroupBytes; k++) begin
        if (keep[k] && (prefix[k] == count_t'(j))) begin
          packed_bytes[j] = s1_bytes[k];
        end
      end
    end
  end

  assign base            = s1_frame_start ? '0 : kept_count;
  assign kept_count_next = base + OFFSET_BITS'(nkept);

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_valid  <= 1'b0;
      ser_idx    <= '0;
      kept_count <= '0;
    end else begin
      if (load) begin
        ser_valid  <= 1'b1;
        ser_idx    <= '0;
        kept_count <= kept_count_next;
      end else if (ser_done) begin
        ser_valid <= 1'b0;
      end else if (out_fire) begin
        ser_idx <= ser_idx + count_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ser_nkept  <= nkept;
      ser_bitmap <= keep;
      ser_bytes  <= packed_bytes;
      ser_base   <= base;
    end
  end

  // result drive
  count_t            idx_m1;
  logic [ExtW-1:0]   base_ext;

  assign idx_m1   = ser_idx - count_t'(1);
  assign base_ext = ExtW'(ser_base);

  assign dout.valid       = ser_valid;
  assign dout.kind        = (ser_idx == '0) ? KIND_BITMAP : KIND_BYTE;
  assign dout.payload     = (ser_idx == '0) ? ser_bitmap : ser_bytes[idx_m1[PosW-1:0]];
  assign dout.kept_offset = base_ext[KeptOffsetW-1:0];
  assign dout.group_last  = ser_last;

  // a bitmap that ends its group means nothing was kept
  a_empty_bitmap: assert property (@(posedge clk) disable iff (rst)
    dout.valid && (dout.kind == KIND_BITMAP) && dout.group_last |-> dout.payload == '0)
    else $error("bitmap closes group but is not empty");

  // the next result of a group follows at once with the same offset
  a_group_offset: assert property (@(posedge clk) disable iff (rst)
    out_fire && !dout.group_last |=> dout.valid && $stable(dout.kept_offset))
    else $error("offset changed or gap inside a group");

  // an accepted item always lands in the input register
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> s1_valid)
    else $error("accepted item lost");

  // kept byte results never exceed the kept count
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    ser_valid |-> ser_idx <= ser_nkept)
    else $error("result index past kept count");

endmodule

// File: tb/sv/tb_threshold_bitmap_byte_compactor.sv
// ----------------------------------------------------------------------------
// tb_threshold_bitmap_byte_compactor - self-checking bench for the compactor
// Drives pixel groups and keep_threshold writes, predicts the bitmap and kept
// byte stream of each group with its own model, and checks every result in
// order, in most phases under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_threshold_bitmap_byte_compactor
  import tbbc_pkg::*;
;

  localparam int HalfPeriod  = 6;
  localparam int ResetCycles = 4;
  localparam int RandomItems = 220;
  localparam int PhaseCount  = 5;
  localparam int SettleCycles = 6;

  typedef logic [KeptOffsetW-1:0] offset_t;

  typedef struct packed {
    logic    kind;
    byte_t   payload;
    offset_t kept_offset;
    logic    group_last;
  } result_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic              pready;

  tbbc_in_if  pix_ch ();
  tbbc_out_if res_ch ();

  threshold_bitmap_byte_compactor DUT (
    .clk     (clk),
    .rst     (rst),
    .din     (pix_ch),
    .dout    (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // bench copy of the block state
  byte_t   model_threshold;
  offset_t model_kept_count;
  result_t expected_results [$];
  result_t want_result;
  int      error_count = 0;
  bit      source_gaps = 1'b0;
  bit      sink_stalls = 1'b0;
  int      stall_left  = 0;

  always #HalfPeriod clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    error_count++;
  endtask

  // mostly zero or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(20, 40);
  endfunction

  function automatic group_t uniform_group(input byte_t v);
    group_t g;
    foreach (g[k]) g[k] = v;
    return g;
  endfunction

  // values around the threshold matter most
  function automatic byte_t pick_pixel();
    case ($urandom_range(0, 7))
      0: return model_threshold;
      1: return model_threshold - 8'd1;
      2: return 8'h00;
      3: return 8'hFF;
      default: return byte_t'($urandom);
    endcase
  endfunction

  function automatic void predict_group(input group_t g, input logic fs);
    bitmap_t keep_map;
    byte_t   kept [$];
    result_t r;
    if (fs) model_kept_count = '0;
    keep_map = '0;
    for (int k = 0; k < GroupBytes; k++) begin
      if (g[k] >= model_threshold) begin
        keep_map[k] = 1'b1;
        kept.push_back(g[k]);
      end
    end
    r.kind        = KIND_BITMAP;
    r.payload     = keep_map;
    r.kept_offset = model_kept_count;
    r.group_last  = (kept.size() == 0);
    expected_results.push_back(r);
    foreach (kept[k]) begin
      r.kind       = KIND_BYTE;
      r.payload    = kept[k];
      r.group_last = (k == kept.size() - 1);
      expected_results.push_back(r);
    end
    model_kept_count = model_kept_count + offset_t'(kept.size());
  endfunction

  // valid stays high across back-to-back items
  task automatic send_group(input group_t g, input logic fs);
    int gap;
    gap = source_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_ch.valid       <= 1'b1;
    pix_ch.byte_0      <= g[0];
    pix_ch.byte_1      <= g[1];
    pix_ch.byte_2      <= g[2];
    pix_ch.byte_3      <= g[3];
    pix_ch.byte_4      <= g[4];
    pix_ch.byte_5      <= g[5];
    pix_ch.byte_6      <= g[6];
    pix_ch.byte_7      <= g[7];
    pix_ch.frame_start <= fs;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    predict_group(g, fs);
  endtask

  task automatic wait_drained();
    pix_ch.valid <= 1'b0;
    while (expected_results.size() > 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // write, then read back
  task automatic write_threshold(input byte_t value);
    logic [PdataW-1:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PaddrW'(4 * REG_KEEP_THRESHOLD);
    pwdata  <= PdataW'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    model_threshold = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback[ByteW-1:0] !== value)
      report_mismatch($sformatf("keep_threshold reads %0d, wrote %0d",
                                readback[ByteW-1:0], value));
  endtask

  // result sink: random stalls when enabled
  always @(posedge clk) begin
    if (rst || !sink_stalls) begin
      res_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      res_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      res_ch.ready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind=%0b payload=%02h",
                                  res_ch.kind, res_ch.payload));
      end else begin
        want_result = expected_results.pop_front();
        if (res_ch.kind !== want_result.kind)
          report_mismatch($sformatf("kind %0b, want %0b",
                                    res_ch.kind, want_result.kind));
        if (res_ch.payload !== want_result.payload)
          report_mismatch($sformatf("payload %02h, want %02h",
                                    res_ch.payload, want_result.payload));
        if (res_ch.kept_offset !== want_result.kept_offset)
          report_mismatch($sformatf("kept_offset %0d, want %0d",
                                    res_ch.kept_offset, want_result.kept_offset));
        if (res_ch.group_last !== want_result.group_last)
          report_mismatch($sformatf("group_last %0b, want %0b",
                                    res_ch.group_last, want_result.group_last));
      end
    end
  end

  // threshold left at its reset value of 25
  task automatic test_reset_threshold();
    send_group(uniform_group(8'd24), 1'b1);
    send_group(uniform_group(8'd25), 1'b0);
    send_group('{8'd0, 8'd25, 8'd24, 8'd255, 8'd26, 8'd1, 8'd100, 8'd25}, 1'b0);
    send_group(uniform_group(8'd255), 1'b0);
    send_group(uniform_group(8'd0), 1'b1);
    send_group('{8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b0);
    send_group('{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255}, 1'b0);
    wait_drained();
  endtask

  task automatic test_threshold_extremes();
    // zero keeps everything
    write_threshold(8'd0);
    send_group(uniform_group(8'd0), 1'b1);
    send_group('{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80}, 1'b0);
    wait_drained();
    write_threshold(8'd255);
    send_group(uniform_group(8'd254), 1'b0);
    send_group('{8'd255, 8'd254, 8'd0, 8'd255, 8'd1, 8'd128, 8'd255, 8'd127}, 1'b0);
    wait_drained();
    write_threshold(8'd1);
    send_group('{8'd0, 8'd1, 8'd0, 8'd2, 8'd0, 8'd255, 8'd0, 8'd1}, 1'b1);
    wait_drained();
    write_threshold(8'd128);
    send_group('{8'h7F, 8'h80, 8'hFE, 8'h01, 8'h81, 8'h7E, 8'hC0, 8'h3F}, 1'b0);
    send_group('{8'h80, 8'h7F, 8'h80, 8'h7F, 8'h80, 8'h7F, 8'h80, 8'h7F}, 1'b1);
    wait_drained();
  endtask

  // frames of random length, frame_start on each first group, rare stray ones
  task automatic test_random_frames();
    int     per_phase;
    int     sent;
    int     frame_len;
    byte_t  thr;
    group_t g;
    per_phase = RandomItems / PhaseCount;
    for (int p = 0; p < PhaseCount; p++) begin
      case (p)
        1: thr = 8'd0;
        3: thr = 8'd255;
        default: thr = byte_t'($urandom);
      endcase
      write_threshold(thr);
      source_gaps = (p != 0) && (p != 4);
      sink_stalls = (p != 0);
      sent = 0;
      while (sent < per_phase) begin
        frame_len = $urandom_range(1, 20);
        for (int i = 0; i < frame_len && sent < per_phase; i++) begin
          foreach (g[k]) g[k] = pick_pixel();
          send_group(g, (i == 0) || ($urandom_range(0, 31) == 0));
          sent++;
          // hold the source until the sink has caught up
          if (p == 2 && sent == per_phase / 2) begin
            pix_ch.valid <= 1'b0;
            while (expected_results.size() > 0) @(posedge clk);
          end
        end
      end
      wait_drained();
    end
  endtask

  initial begin
    rst                <= 1'b1;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    pix_ch.valid       <= 1'b0;
    pix_ch.byte_0      <= '0;
    pix_ch.byte_1      <= '0;
    pix_ch.byte_2      <= '0;
    pix_ch.byte_3      <= '0;
    pix_ch.byte_4      <= '0;
    pix_ch.byte_5      <= '0;
    pix_ch.byte_6      <= '0;
    pix_ch.byte_7      <= '0;
    pix_ch.frame_start <= 1'b0;
    model_threshold    = ThresholdReset;
    model_kept_count   = '0;
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;

    test_reset_threshold();
    test_threshold_extremes();
    test_random_frames();

    wait_drained();
    if (error_count == 0)
      $display("[threshold_bitmap_byte_compactor] OK");
    else
      $display("[threshold_bitmap_byte_compactor] ERROR");
    $finish;
  end

  initial begin
    #(2 * HalfPeriod * 500000);
    $display("[threshold_bitmap_byte_compactor] ERROR");
    $finish;
  end

endmodule
